/* design/irvp_pkg.sv */
`default_nettype none
package irvp_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam int MODE_W     = 2;
  localparam int HEADING_W  = 15;
  localparam int VEL_W      = 16;
  localparam int TOL_W      = 14;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BUMPER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_MODE = 3'd4;

  localparam logic [VEL_W-1:0] MIN_VEL_RST   = 16'd410;
  localparam logic [VEL_W-1:0] MAX_VEL_RST   = 16'd4096;
  localparam logic [VEL_W-1:0] ACCEL_RST     = 16'd12984;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 14'd410;
  localparam logic             SAFE_MODE_RST = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE,
    ST_RUNNING,
    ST_FINISHED,
    ST_ABORT_COLLISION,
    ST_ABORT_BUMPER
  } status_t;

  // pi in Q2.30, rounded to nearest in the angle format
  localparam longint PI_Q30 = 64'd3373259426;

  function automatic longint pi_fx(input int frac_bits);
    return ((PI_Q30 >> (30 - frac_bits - 1)) + 64'd1) >> 1;
  endfunction

  // bits of pi as an unsigned value
  function automatic int pi_bits(input int frac_bits);
    return $clog2(pi_fx(frac_bits) + 64'd1);
  endfunction

  // signed width of a wrapped angle
  function automatic int angle_w(input int frac_bits);
    return pi_bits(frac_bits) + 1;
  endfunction

  // signed width of a value handed to the wrap unit
  function automatic int wrap_in_w(input int frac_bits);
    return (pi_bits(frac_bits) + 2 > HEADING_W) ? pi_bits(frac_bits) + 2 : HEADING_W;
  endfunction

endpackage
`default_nettype wire

/* design/irvp_wrap.sv */
`default_nettype none
module irvp_wrap #(
  parameter int ANGLE_FRAC_BITS = irvp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                                    clk,
  input  wire logic                                                    rst,
  input  wire logic                                                    start,
  input  wire logic signed [irvp_pkg::wrap_in_w(ANGLE_FRAC_BITS)-1:0] value,
  output logic                                                         done,
  output logic signed [irvp_pkg::angle_w(ANGLE_FRAC_BITS)-1:0]         result
);

  localparam longint PI     = irvp_pkg::pi_fx(ANGLE_FRAC_BITS);
  localparam longint TWO_PI = 2 * PI;
  localparam int     PW     = irvp_pkg::pi_bits(ANGLE_FRAC_BITS);
  localparam int     AW     = irvp_pkg::angle_w(ANGLE_FRAC_BITS);
  localparam int     IW     = irvp_pkg::wrap_in_w(ANGLE_FRAC_BITS);
  localparam int     UW     = IW + 1;
  localparam longint HALF   = longint'(1) << (IW - 1);
  localparam longint BIAS   = TWO_PI * ((HALF + TWO_PI - 1) / TWO_PI);
  localparam int     STEPS  = UW - PW;
  localparam int     CW     = $clog2(STEPS + 1);

  logic [UW-1:0] rem;
  logic [UW-1:0] div;
  logic [CW-1:0] cnt;
  logic          busy;
  logic signed [AW:0] rem_s;

  // restoring remainder by 2*pi, one subtract per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {value[IW-1], value} + UW'(BIAS);
        div  <= UW'(TWO_PI) << (STEPS - 1);
        cnt  <= CW'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= div) begin
          rem <= rem - div;
        end
        div <= div >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_s  = $signed({1'b0, rem[PW:0]});
  assign result = (rem_s > $signed((AW+1)'(PI))) ? AW'(rem_s - $signed((AW+1)'(TWO_PI)))
                                                  : AW'(rem_s);

endmodule
`default_nettype wire

/* design/irvp_isqrt.sv */
`default_nettype none
module irvp_isqrt #(
  parameter int ARG_W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [ARG_W-1:0]       arg,
  output logic                        done,
  output logic [(ARG_W+1)/2-1:0]      root
);

  localparam int N  = (ARG_W + 1) / 2;
  localparam int CW = $clog2(N + 1);

  logic [2*N-1:0] acc;
  logic [N:0]     rem;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [N+2:0]   rem_sh;
  logic [N+2:0]   trial;
  logic [N+2:0]   diff;

  // one result bit per cycle
  assign rem_sh = {rem, acc[2*N-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= (2*N)'(arg);
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(N);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc << 2;
        if (rem_sh >= trial) begin
          rem  <= diff[N:0];
          root <= {root[N-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[N:0];
          root <= {root[N-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/in_place_rotation_velocity_profile.sv */
// In-place full-turn velocity profile.
// Input channel (in_valid/in_stall) carries mode, heading and path_blocked; a
// start item latches the turn origin, a tick returns the commanded turn_rate
// and status, a bumper item is stored for the next tick. Every request gives
// exactly one result on the output channel (out_valid/out_stall).
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and writes to unknown indexes are dropped.
// A tick of a running turn runs the angle wrap unit twice (one subtract a
// cycle, three steps at the default format), one multiply, then the
// square-root unit at one result bit per cycle.
// One request is worked on at a time; in_stall is high until its result has
// entered the output register.
// The output register holds a result while out_stall is high, and a new
// request is already taken in meanwhile; the next result waits inside.
// Reset (rst, synchronous) restores the register defaults, ends any turn and
// clears the stored flags and empties the output register.
`default_nettype none
module in_place_rotation_velocity_profile #(
  parameter int ANGLE_FRAC_BITS = irvp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [irvp_pkg::MODE_W-1:0]            mode,
  input  wire logic signed [irvp_pkg::HEADING_W-1:0]  heading,
  input  wire logic                                   path_blocked,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [irvp_pkg::VEL_W-1:0]                  turn_rate,
  output logic [irvp_pkg::STATUS_W-1:0]               status,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [irvp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [irvp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam longint PI   = irvp_pkg::pi_fx(ANGLE_FRAC_BITS);
  localparam int     AW   = irvp_pkg::angle_w(ANGLE_FRAC_BITS);
  localparam int     IW   = irvp_pkg::wrap_in_w(ANGLE_FRAC_BITS);
  localparam int     VW_C = irvp_pkg::VEL_W;
  localparam int     PRW  = VW_C + AW + 1;
  localparam int     SH_L = (ANGLE_FRAC_BITS <= 12) ? 12 - ANGLE_FRAC_BITS : 0;
  localparam int     SH_R = (ANGLE_FRAC_BITS > 12) ? ANGLE_FRAC_BITS - 12 : 0;
  localparam int     AGW  = PRW + SH_L - SH_R;
  localparam int     RTW  = (AGW + 1) / 2;
  localparam int     VW   = (RTW > VW_C) ? RTW : VW_C;
  localparam int     CMPW = ((AW > irvp_pkg::TOL_W) ? AW : irvp_pkg::TOL_W) + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP_H,
    S_WRAP_S,
    S_CHECK,
    S_MUL,
    S_ROOT_GO,
    S_ROOT,
    S_OUT
  } fsm_t;

  fsm_t state;

  logic [VW_C-1:0]               min_vel;
  logic [VW_C-1:0]               max_vel;
  logic [VW_C-1:0]               accel;
  logic [irvp_pkg::TOL_W-1:0]    tol;
  logic                          safe;

  logic signed [AW-1:0]          start_offset;
  logic                          passed_half;
  logic                          bumper_seen;
  logic                          turning;

  logic [irvp_pkg::MODE_W-1:0]   mode_q;
  logic                          blocked_q;
  logic signed [AW-1:0]          cur;
  logic [AW-1:0]                 dist_q;
  logic [PRW-1:0]                prod;
  logic [VW_C-1:0]               res_rate;
  irvp_pkg::status_t             res_status;

  logic                          accept;
  logic                          wrap_start;
  logic signed [IW-1:0]          wrap_value;
  logic                          wrap_done;
  logic signed [AW-1:0]          wrap_res;
  logic                          sq_start;
  logic [AGW-1:0]                sq_arg;
  logic [PRW+SH_L-1:0]           prod_wide;
  logic                          sq_done;
  logic [RTW-1:0]                sq_root;

  logic signed [AW:0]            dist_s;
  logic [VW-1:0]                 vel_lo;
  logic [VW_C-1:0]               vel;
  logic signed [CMPW-1:0]        cur_ext;
  logic signed [CMPW-1:0]        tol_neg;
  logic                          ph_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  assign wrap_start = (accept && (mode == irvp_pkg::MODE_START ||
                                  (mode == irvp_pkg::MODE_TICK && turning))) ||
                      (state == S_WRAP_H && wrap_done && mode_q != irvp_pkg::MODE_START);
  assign wrap_value = (state == S_IDLE) ? IW'(heading) : IW'(wrap_res) + IW'(start_offset);

  assign sq_start  = (state == S_ROOT_GO);
  assign prod_wide = (PRW+SH_L)'(prod) << SH_L;
  assign sq_arg    = AGW'(prod_wide >> SH_R);

  assign dist_s  = $signed((AW+1)'(PI)) - (AW+1)'(cur);
  assign vel_lo  = (VW'(sq_root) < VW'(min_vel)) ? VW'(min_vel) : VW'(sq_root);
  assign vel     = (vel_lo > VW'(max_vel)) ? max_vel : vel_lo[VW_C-1:0];
  assign cur_ext = CMPW'(cur);
  assign tol_neg = -$signed({{(CMPW-irvp_pkg::TOL_W){1'b0}}, tol});
  assign ph_new  = passed_half || (cur < 0);

  irvp_wrap #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (wrap_start),
    .value (wrap_value),
    .done  (wrap_done),
    .result(wrap_res)
  );

  irvp_isqrt #(
    .ARG_W(AGW)
  ) u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .arg  (sq_arg),
    .done (sq_done),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      min_vel      <= irvp_pkg::MIN_VEL_RST;
      max_vel      <= irvp_pkg::MAX_VEL_RST;
      accel        <= irvp_pkg::ACCEL_RST;
      tol          <= irvp_pkg::TOLERANCE_RST;
      safe         <= irvp_pkg::SAFE_MODE_RST;
      start_offset <= '0;
      passed_half  <= 1'b0;
      bumper_seen  <= 1'b0;
      turning      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          irvp_pkg::REG_MIN_VEL:   min_vel <= cfg_data;
          irvp_pkg::REG_MAX_VEL:   max_vel <= cfg_data;
          irvp_pkg::REG_ACCEL:     accel   <= cfg_data;
          irvp_pkg::REG_TOLERANCE: tol     <= cfg_data[irvp_pkg::TOL_W-1:0];
          irvp_pkg::REG_SAFE_MODE: safe    <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= mode;
            blocked_q <= path_blocked;
            res_rate  <= '0;
            res_status <= turning ? irvp_pkg::ST_RUNNING : irvp_pkg::ST_IDLE;
            if (mode == irvp_pkg::MODE_START ||
                (mode == irvp_pkg::MODE_TICK && turning)) begin
              state <= S_WRAP_H;
            end else begin
              if (mode == irvp_pkg::MODE_BUMPER) begin
                bumper_seen <= 1'b1;
              end
              state <= S_OUT;
            end
          end
        end
        S_WRAP_H: begin
          if (wrap_done) begin
            if (mode_q == irvp_pkg::MODE_START) begin
              start_offset <= -wrap_res;
              passed_half  <= 1'b0;
              bumper_seen  <= 1'b0;
              turning      <= 1'b1;
              res_status   <= irvp_pkg::ST_RUNNING;
              state        <= S_OUT;
            end else begin
              state <= S_WRAP_S;
            end
          end
        end
        S_WRAP_S: begin
          if (wrap_done) begin
            cur   <= wrap_res;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          dist_q <= dist_s[AW-1:0];
          if (safe && blocked_q && dist_s != '0) begin
            turning    <= 1'b0;
            res_status <= irvp_pkg::ST_ABORT_COLLISION;
            state      <= S_OUT;
          end else if (!safe && bumper_seen) begin
            turning    <= 1'b0;
            res_status <= irvp_pkg::ST_ABORT_BUMPER;
            state      <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= {(PRW-1)'(accel) * (PRW-1)'(dist_q), 1'b0};
          state <= S_ROOT_GO;
        end
        S_ROOT_GO: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            res_rate    <= vel;
            passed_half <= ph_new;
            if (ph_new && cur_ext >= tol_neg) begin
              turning    <= 1'b0;
              res_status <= irvp_pkg::ST_FINISHED;
            end else begin
              res_status <= irvp_pkg::ST_RUNNING;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            turn_rate <= res_rate;
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/irvp_checker.sv */
`default_nettype none
module irvp_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic [irvp_pkg::MODE_W-1:0]           mode,
  input wire logic signed [irvp_pkg::HEADING_W-1:0] heading,
  input wire logic                                  path_blocked,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [irvp_pkg::VEL_W-1:0]            turn_rate,
  input wire logic [irvp_pkg::STATUS_W-1:0]         status,
  input wire logic                                  cfg_valid,
  input wire logic                                  cfg_ready,
  input wire logic [irvp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input wire logic [irvp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(turn_rate) && $stable(status))
    else $error("result changed while stalled");

  // every taken request makes the block busy in the cycle after
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without going busy");

  // aborted or idle results carry zero rate
  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == irvp_pkg::ST_IDLE || status == irvp_pkg::ST_ABORT_COLLISION ||
                  status == irvp_pkg::ST_ABORT_BUMPER) |-> turn_rate == '0)
    else $error("nonzero rate without driving");

  // reset leaves an empty output and an open input
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall && cfg_ready)
    else $error("state after reset");

endmodule

bind in_place_rotation_velocity_profile irvp_checker u_irvp_checker (.*);
`default_nettype wire
